FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bmws_pkg.sv
// ---------------------------------------------------------------------------
// bmws_pkg
// Shared constants, payload types and controller/datapath interface structs.
// ---------------------------------------------------------------------------
package bmws_pkg;

    localparam int MAX_ITEMS  = 4096;
    localparam int VALUE_BITS = 16;
    localparam int LIMIT_BITS = 32;
    localparam int SUM_BITS   = LIMIT_BITS + 1;
    localparam int POS_BITS   = $clog2(MAX_ITEMS + 1);
    localparam int ADDR_BITS  = $clog2(MAX_ITEMS);

    typedef struct packed {
        logic [VALUE_BITS-1:0] count_value;
        logic                  is_last;
    } in_item_t;

    typedef struct packed {
        logic                found;
        logic [POS_BITS-1:0] first_position;
        logic [POS_BITS-1:0] last_position;
        logic                overflow;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic store;          // append the accepted count at the tail
        logic mark_overflow;  // accepted count dropped, store full
        logic capture_last;   // latch the last mark of the accepted item
        logic shrink_step;    // drop the count at the head
        logic best_load;      // current window becomes the best
        logic out_load;       // load the result register
        logic seq_clear;      // return sequence state to reset values
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic tail_full;      // tail has reached the store depth
        logic in_last;        // last mark on the offered input item
        logic last_pending;   // item in flight carries the last mark
        logic over_limit;     // running sum exceeds the limit
        logic win_nonempty;   // head below tail
        logic better;         // window beats the best so far
        logic out_free;       // result register can take a new result
    } dp_status_t;

endpackage

FILE: rtl/bmws_ctrl.sv
// ---------------------------------------------------------------------------
// bmws_ctrl
// Sequencer: accept an item, shrink the window one count a cycle, report.
// ---------------------------------------------------------------------------
module bmws_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  bmws_pkg::dp_status_t stat,
    output bmws_pkg::dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SHRINK = 3'b010,
        ST_REPORT = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // Next state and command decode
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture_last = 1'b1;
                    if (stat.tail_full) begin
                        cmd.mark_overflow = 1'b1;
                        state_next = stat.in_last ? ST_REPORT : ST_IDLE;
                    end else begin
                        cmd.store  = 1'b1;
                        state_next = ST_SHRINK;
                    end
                end
            end
            ST_SHRINK: begin
                if (stat.over_limit && stat.win_nonempty) begin
                    cmd.shrink_step = 1'b1;
                end else begin
                    cmd.best_load = stat.win_nonempty && stat.better;
                    state_next    = stat.last_pending ? ST_REPORT : ST_IDLE;
                end
            end
            ST_REPORT: begin
                if (stat.out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.seq_clear = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/bmws_dp.sv
// ---------------------------------------------------------------------------
// bmws_dp
// Window store, running sum, head/tail, best run and result register.
// ---------------------------------------------------------------------------
module bmws_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bmws_pkg::LIMIT_BITS-1:0]      cfg_data,
    input  bmws_pkg::in_item_t                   s_payload,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output bmws_pkg::out_item_t                  m_payload,
    input  bmws_pkg::dp_cmd_t                    cmd,
    output bmws_pkg::dp_status_t                 stat
);

    localparam int SB = bmws_pkg::SUM_BITS;
    localparam int PB = bmws_pkg::POS_BITS;
    localparam int AB = bmws_pkg::ADDR_BITS;
    localparam int VB = bmws_pkg::VALUE_BITS;

    logic [VB-1:0] store_mem [bmws_pkg::MAX_ITEMS];
    logic [VB-1:0] head_data_reg;

    logic [bmws_pkg::LIMIT_BITS-1:0] limit_reg;
    logic [SB-1:0] sum_reg, sum_next;
    logic [PB-1:0] head_reg, head_next;
    logic [PB-1:0] tail_reg, tail_next;
    logic          last_reg;
    logic          overflowed_reg;
    logic          best_valid_reg;
    logic [SB-1:0] best_sum_reg;
    logic [PB-1:0] best_start_reg;
    logic [PB-1:0] best_end_reg;
    logic          m_valid_reg;
    bmws_pkg::out_item_t out_reg;

    logic [AB-1:0] wr_addr;
    logic [AB-1:0] rd_addr;

    assign cfg_ready = 1'b1;

    // Limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= '0;
        end else if (cfg_valid) begin
            limit_reg <= cfg_data;
        end
    end

    // Window bounds and running sum
    always_comb begin
        sum_next  = sum_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        if (cmd.seq_clear) begin
            sum_next  = '0;
            head_next = '0;
            tail_next = '0;
        end else if (cmd.store) begin
            sum_next  = sum_reg + SB'(s_payload.count_value);
            tail_next = tail_reg + PB'(1);
        end else if (cmd.shrink_step) begin
            sum_next  = sum_reg - SB'(head_data_reg);
            head_next = head_reg + PB'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg  <= '0;
            head_reg <= '0;
            tail_reg <= '0;
        end else begin
            sum_reg  <= sum_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    // Store: write at tail, read ahead at the next head, bypass a same-cycle write
    assign wr_addr = tail_reg[AB-1:0];
    assign rd_addr = head_next[AB-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.store) begin
            store_mem[wr_addr] <= s_payload.count_value;
        end
        if (cmd.store && (wr_addr == rd_addr)) begin
            head_data_reg <= s_payload.count_value;
        end else begin
            head_data_reg <= store_mem[rd_addr];
        end
    end

    // Sequence flags and best run
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg       <= 1'b0;
            overflowed_reg <= 1'b0;
            best_valid_reg <= 1'b0;
            best_sum_reg   <= '0;
            best_start_reg <= '0;
            best_end_reg   <= '0;
        end else begin
            if (cmd.capture_last) begin
                last_reg <= s_payload.is_last;
            end
            if (cmd.seq_clear) begin
                overflowed_reg <= 1'b0;
                best_valid_reg <= 1'b0;
                best_sum_reg   <= '0;
                best_start_reg <= '0;
                best_end_reg   <= '0;
            end else begin
                if (cmd.mark_overflow) begin
                    overflowed_reg <= 1'b1;
                end
                if (cmd.best_load) begin
                    best_valid_reg <= 1'b1;
                    best_sum_reg   <= sum_reg;
                    best_start_reg <= head_reg;
                    best_end_reg   <= tail_reg;
                end
            end
        end
    end

    // Result register: hold until transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg.found          <= best_valid_reg;
            out_reg.first_position <= best_valid_reg ? (best_start_reg + PB'(1)) : '0;
            out_reg.last_position  <= best_valid_reg ? best_end_reg : '0;
            out_reg.overflow       <= overflowed_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

    // Status to the controller
    always_comb begin
        stat.tail_full    = (tail_reg == PB'(bmws_pkg::MAX_ITEMS));
        stat.in_last      = s_payload.is_last;
        stat.last_pending = last_reg;
        stat.over_limit   = (sum_reg > SB'(limit_reg));
        stat.win_nonempty = (head_reg < tail_reg);
        stat.better       = !best_valid_reg || (sum_reg > best_sum_reg);
        stat.out_free     = !m_valid_reg || m_ready;
    end

endmodule

FILE: rtl/bounded_max_window_sum.sv
// ---------------------------------------------------------------------------
// bounded_max_window_sum
// Earliest largest contiguous run of counts whose sum stays within a limit.
// ---------------------------------------------------------------------------
//  channel  | ports                          | moves
//  ---------+--------------------------------+-------------------------------
//  config   | cfg_valid cfg_ready cfg_data   | sum_limit write, always ready
//  input    | s_valid s_ready s_payload      | one count and last mark
//  result   | m_valid m_ready m_payload      | one result per last item
//
// An item is accepted, then the head drops counts while the sum exceeds the
// limit, then the window is checked against the best run; each count is dropped
// at most once, and no new item is taken until this is done. A count arriving
// at a full store is dropped and marked as overflow. The single read port of the
// window store paces the head drops: one head entry is read per cycle.
// A last item then adds a report step, which waits while the previous result waits.
// Reset needs no clearing pass; the store is read only where written.
// ---------------------------------------------------------------------------
module bounded_max_window_sum (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bmws_pkg::LIMIT_BITS-1:0]   cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  bmws_pkg::in_item_t                s_payload,
    output logic                              m_valid,
    input  logic                              m_ready,
    output bmws_pkg::out_item_t               m_payload
);

`include "assert_macros.svh"

    bmws_pkg::dp_cmd_t    cmd;
    bmws_pkg::dp_status_t stat;

    bmws_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bmws_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cmd       (cmd),
        .stat      (stat)
    );

    // A stored item is always followed by a limit check before the next transfer
    `ASSERT_NEXT(a_store_then_busy, s_valid && s_ready && !stat.tail_full, !s_ready, "input taken during window check")
    // Never overwrite a result that still waits for transfer
    `ASSERT_IMPLY(a_out_no_clobber, cmd.out_load, stat.out_free, "pending result overwritten")
    // The best run is only taken from a nonempty window within the limit
    `ASSERT_IMPLY(a_best_fits, cmd.best_load, stat.win_nonempty && !stat.over_limit, "best run exceeds limit")

endmodule

FILE: dv/bounded_max_window_sum_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// bounded_max_window_sum_test
// Drives sequences of counts into bounded_max_window_sum and checks every
// result against a cycle-free predictor of the best run within the limit.
// Covers the reset limit, extreme limits, zero-sum runs, runs that never fit,
// limit changes inside a sequence, a long result stall that backs up the
// input, and random idling on both sides.
// ---------------------------------------------------------------------------
module bounded_max_window_sum_test;

    localparam int VB    = bmws_pkg::VALUE_BITS;
    localparam int LB    = bmws_pkg::LIMIT_BITS;
    localparam int SB    = bmws_pkg::SUM_BITS;
    localparam int PB    = bmws_pkg::POS_BITS;
    localparam int DEPTH = bmws_pkg::MAX_ITEMS;

    localparam int STALL_LIMIT     = 10000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PHASE_ITEMS     = 185;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [LB-1:0]       cfg_data  = '0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    bmws_pkg::in_item_t  s_payload = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    bmws_pkg::out_item_t m_payload;

    // Predictor state for the sequence in flight
    logic [VB-1:0]       win_counts [DEPTH];
    logic [SB-1:0]       win_total     = '0;
    logic [SB-1:0]       best_total    = '0;
    int unsigned         win_head      = 0;
    int unsigned         win_tail      = 0;
    int unsigned         best_from     = 0;
    int unsigned         best_to       = 0;
    logic                best_found    = 1'b0;
    logic                store_overrun = 1'b0;
    logic [LB-1:0]       sum_limit_cfg = '0;
    bmws_pkg::out_item_t expected_results [$];

    int error_count    = 0;
    int src_gap_pct    = 0;
    int sink_stall_pct = 0;
    int hold_request   = 0;
    int hold_left      = 0;
    int idle_cycles    = 0;
    int items_sent     = 0;

    bounded_max_window_sum DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (error_count < 50) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
        error_count++;
    endtask

    task automatic clear_run();
        win_total     = '0;
        win_head      = 0;
        win_tail      = 0;
        best_found    = 1'b0;
        best_total    = '0;
        best_from     = 0;
        best_to       = 0;
        store_overrun = 1'b0;
    endtask

    // Append one count, shrink the window against the limit, track the best run
    task automatic predict_best_run(input bmws_pkg::in_item_t item);
        bmws_pkg::out_item_t res;
        if (win_tail >= DEPTH) begin
            store_overrun = 1'b1;
        end else begin
            win_counts[win_tail] = item.count_value;
            win_tail++;
            win_total += item.count_value;
            while (win_total > {1'b0, sum_limit_cfg} && win_head < win_tail) begin
                win_total -= win_counts[win_head];
                win_head++;
            end
            if (win_head < win_tail && (!best_found || win_total > best_total)) begin
                best_found = 1'b1;
                best_total = win_total;
                best_from  = win_head;
                best_to    = win_tail;
            end
        end
        if (item.is_last) begin
            res.found          = best_found;
            res.first_position = best_found ? PB'(best_from + 1) : '0;
            res.last_position  = best_found ? PB'(best_to) : '0;
            res.overflow       = store_overrun;
            expected_results.insert(expected_results.size(), res);
            clear_run();
        end
    endtask

    // Offer one item, idling first at the sender's rate, and hold it until transfer
    task automatic send_count(input logic [VB-1:0] value, input logic last);
        bmws_pkg::in_item_t item;
        item.count_value = value;
        item.is_last     = last;
        while ($urandom_range(99) < src_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_best_run(item);
        items_sent++;
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    // Write the limit once the block is idle; allow for head drops still running
    task automatic write_limit(input logic [LB-1:0] value);
        int settle;
        drain_results();
        settle = win_tail + 16;
        repeat (settle) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sum_limit_cfg = value;
        cfg_valid <= 1'b0;
    endtask

    // Counts: zero, full scale, anything, or scaled to the limit so windows shrink
    function automatic logic [VB-1:0] pick_count();
        int unsigned span;
        span = (sum_limit_cfg > 65535) ? 65535 : sum_limit_cfg;
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return VB'($urandom_range(0, 65535));
            default: return VB'($urandom_range(0, span / 2 + 1));
        endcase
    endfunction

    function automatic logic [LB-1:0] pick_limit();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            2:       return $urandom_range(1, 64);
            3:       return $urandom_range(65, 200000);
            4:       return $urandom();
            default: return $urandom_range(65535, 1000000);
        endcase
    endfunction

    // One sequence of random counts, the final one marked last
    task automatic send_run(input int len, input bit allow_retune);
        for (int i = 0; i < len; i++) begin
            if (allow_retune && i != 0 && $urandom_range(39) == 0) begin
                write_limit(pick_limit());
            end
            send_count(pick_count(), i == len - 1);
        end
    endtask

    // Check each result transfer against the oldest expectation
    always @(posedge aclk) begin : check_results
        bmws_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result with none expected: %p", m_payload));
            end else begin
                want = expected_results.pop_front();
                if (m_payload.found !== want.found)
                    report_mismatch($sformatf("found %0b, expected %0b",
                                              m_payload.found, want.found));
                if (m_payload.first_position !== want.first_position)
                    report_mismatch($sformatf("first_position %0d, expected %0d",
                                              m_payload.first_position,
                                              want.first_position));
                if (m_payload.last_position !== want.last_position)
                    report_mismatch($sformatf("last_position %0d, expected %0d",
                                              m_payload.last_position,
                                              want.last_position));
                if (m_payload.overflow !== want.overflow)
                    report_mismatch($sformatf("overflow %0b, expected %0b",
                                              m_payload.overflow, want.overflow));
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested
    always @(posedge aclk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Abort when no transfer happens on any channel for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic test_directed();
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        // Reset limit of zero: only zero counts fit, earliest zero wins
        send_count(16'd0, 1'b0);
        send_count(16'd5, 1'b0);
        send_count(16'd0, 1'b1);
        // Nothing fits
        send_count(16'd7, 1'b1);
        // Widest limit: full-scale counts all fit
        write_limit('1);
        send_count(16'hFFFF, 1'b0);
        send_count(16'hFFFF, 1'b0);
        send_count(16'd0, 1'b0);
        send_count(16'hFFFF, 1'b1);
        // Small limit: head advances several times
        write_limit(32'd10);
        send_count(16'd3, 1'b0);
        send_count(16'd4, 1'b0);
        send_count(16'd5, 1'b0);
        send_count(16'd2, 1'b0);
        send_count(16'd9, 1'b0);
        send_count(16'd1, 1'b1);
        // Single count exactly at the limit, then just above it
        send_count(16'd10, 1'b1);
        send_count(16'd11, 1'b1);
        // Tighten the limit inside a sequence
        send_count(16'd6, 1'b0);
        send_count(16'd3, 1'b0);
        write_limit(32'd5);
        send_count(16'd1, 1'b1);
        send_count(16'd0, 1'b1);
    endtask

    task automatic test_result_backpressure();
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        write_limit(32'd200000);
        // Hold the result side off while the sender keeps offering short sequences
        hold_request = HOLD_OFF_CYCLES;
        for (int i = 0; i < 30; i++) begin
            send_run($urandom_range(1, 3), 1'b0);
        end
        // Pause the sender until everything has come back
        drain_results();
        for (int i = 0; i < 10; i++) begin
            send_run($urandom_range(1, 4), 1'b0);
        end
    endtask

    task automatic test_idle_phases();
        int gap_pct   [4] = '{0, 47, 0, 28};
        int stall_pct [4] = '{0, 0, 47, 28};
        int target;
        for (int p = 0; p < 4; p++) begin
            src_gap_pct    = gap_pct[p];
            sink_stall_pct = stall_pct[p];
            write_limit(pick_limit());
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                if ($urandom_range(4) == 0) begin
                    write_limit(pick_limit());
                end
                send_run(($urandom_range(9) == 0) ? $urandom_range(25, 150)
                                                  : $urandom_range(1, 24), 1'b1);
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_result_backpressure();
        test_idle_phases();
        drain_results();
        repeat (32) @(posedge aclk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: bounded_max_window_sum.f
+incdir+rtl
rtl/bmws_pkg.sv
rtl/bmws_ctrl.sv
rtl/bmws_dp.sv
rtl/bounded_max_window_sum.sv
dv/bounded_max_window_sum_test.sv
